// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/owrs_pkg.sv =====
`timescale 1ns / 1ps

package owrs_pkg;

  localparam int CODE_BITS = 64;
  localparam int CRC_BYTES = 7;
  localparam int CRC_LAST_POS = CRC_BYTES * 8;
  localparam int POS_W = 7;
  localparam int IDX_W = 6;
  localparam int CNT_W = 8;
  localparam int CRC_W = 8;
  localparam logic [CRC_W-1:0] CRC_POLY = 8'h8C;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_MAX_DEVICES = 1'b0;
  localparam logic [CNT_W-1:0] MAX_DEVICES_RST = 8'd16;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_BITS = 1'b1;

  typedef enum logic [2:0] {
    ST_BIT    = 3'd0,
    ST_MORE   = 3'd1,
    ST_DONE   = 3'd2,
    ST_NODEV  = 3'd3,
    ST_CRCERR = 3'd4,
    ST_IDLE   = 3'd5
  } status_t;

  typedef struct packed {
    logic op;
    logic bus_bit;
    logic bus_bit_complement;
  } in_req_t;

  typedef struct packed {
    logic                 write_bit;
    status_t              status;
    logic [CODE_BITS-1:0] rom_code;
    logic [CNT_W-1:0]     device_count;
  } out_rsp_t;

endpackage

// ===== sv/onewire_rom_search.sv =====
// Channel   Ports                                   Payload
// in        in_valid / in_ready / in_data           owrs_pkg::in_req_t
// out       out_valid / out_ready / out_data        owrs_pkg::out_rsp_t
// cfg       cfg_psel .. cfg_pready (APB write/read) max_devices at 0x0
//
// One request per cycle; each result appears in the cycle after its request is taken.
// The path, branch, CRC and count registers and the result register update in one edge.
// in_ready is high whenever the result register is empty or being drained.
// A stalled result holds; no request is taken until it leaves.
// Synchronous active-low reset clears all search state; max_devices returns to 16.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module onewire_rom_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  owrs_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output owrs_pkg::out_rsp_t                  out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [owrs_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [owrs_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [owrs_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  logic [owrs_pkg::CNT_W-1:0]     max_dev_r;
  logic [owrs_pkg::CODE_BITS-1:0] path_r, path_nxt, path_upd;
  logic [owrs_pkg::POS_W-1:0]     last_br_r, last_br_nxt;
  logic [owrs_pkg::POS_W-1:0]     new_br_r, new_br_nxt, new_br_upd;
  logic [owrs_pkg::POS_W-1:0]     bit_pos_r, bit_pos_nxt;
  logic [owrs_pkg::CNT_W-1:0]     count_r, count_nxt, count_inc;
  logic                           active_r, active_nxt;
  logic [owrs_pkg::CRC_W-1:0]     crc_r, crc_nxt, crc_stepped;
  logic                           out_valid_r, out_valid_nxt;
  owrs_pkg::out_rsp_t             out_data_r, out_data_nxt;

  logic                           in_fire, cfg_wr;
  logic [owrs_pkg::POS_W-1:0]     pos;
  logic [owrs_pkg::IDX_W-1:0]     idx;
  logic                           chosen, discrepancy;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[owrs_pkg::CFG_ADDR_W-1:2] == owrs_pkg::REG_MAX_DEVICES);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[owrs_pkg::CFG_ADDR_W-1:2] == owrs_pkg::REG_MAX_DEVICES) begin
      cfg_prdata = {{(owrs_pkg::CFG_DATA_W-owrs_pkg::CNT_W){1'b0}}, max_dev_r};
    end
  end

  assign pos = ((bit_pos_r == '0) || (bit_pos_r > owrs_pkg::POS_W'(owrs_pkg::CODE_BITS)))
               ? owrs_pkg::POS_W'(1) : bit_pos_r;
  assign idx = owrs_pkg::IDX_W'(pos - owrs_pkg::POS_W'(1));
  assign discrepancy = !in_data.bus_bit && !in_data.bus_bit_complement;

  always_comb begin
    chosen = in_data.bus_bit;
    new_br_upd = new_br_r;
    if (discrepancy) begin
      priority if (pos < last_br_r) begin
        chosen = path_r[idx];
      end else if (pos == last_br_r) begin
        chosen = 1'b1;
      end else begin
        chosen = 1'b0;
      end
      if (!chosen) begin
        new_br_upd = pos;
      end
    end
  end

  always_comb begin
    path_upd = path_r;
    path_upd[idx] = chosen;
  end

  assign crc_stepped = {1'b0, crc_r[owrs_pkg::CRC_W-1:1]} ^
                       ((crc_r[0] ^ chosen) ? owrs_pkg::CRC_POLY : '0);
  assign count_inc = (count_r == '1) ? count_r : count_r + owrs_pkg::CNT_W'(1);

  always_comb begin
    path_nxt      = path_r;
    last_br_nxt   = last_br_r;
    new_br_nxt    = new_br_r;
    bit_pos_nxt   = bit_pos_r;
    count_nxt     = count_r;
    active_nxt    = active_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt.write_bit    = 1'b0;
      out_data_nxt.status       = owrs_pkg::ST_IDLE;
      out_data_nxt.rom_code     = '0;
      out_data_nxt.device_count = count_r;
      if (in_data.op == owrs_pkg::OP_BEGIN) begin
        path_nxt    = '0;
        last_br_nxt = '0;
        new_br_nxt  = '0;
        bit_pos_nxt = owrs_pkg::POS_W'(1);
        count_nxt   = '0;
        crc_nxt     = '0;
        active_nxt  = (max_dev_r != '0);
        out_data_nxt.device_count = '0;
      end else if (!active_r) begin
        out_data_nxt.status = owrs_pkg::ST_IDLE;
      end else if (in_data.bus_bit && in_data.bus_bit_complement) begin
        active_nxt = 1'b0;
        out_data_nxt.status = owrs_pkg::ST_NODEV;
      end else begin
        path_nxt   = path_upd;
        new_br_nxt = new_br_upd;
        out_data_nxt.write_bit = chosen;
        if (pos <= owrs_pkg::POS_W'(owrs_pkg::CRC_LAST_POS)) begin
          crc_nxt = crc_stepped;
        end
        if (pos < owrs_pkg::POS_W'(owrs_pkg::CODE_BITS)) begin
          bit_pos_nxt = pos + owrs_pkg::POS_W'(1);
          out_data_nxt.status = owrs_pkg::ST_BIT;
        end else begin
          bit_pos_nxt = owrs_pkg::POS_W'(1);
          crc_nxt = '0;
          if (crc_r != path_upd[owrs_pkg::CODE_BITS-1:owrs_pkg::CRC_LAST_POS]) begin
            active_nxt = 1'b0;
            out_data_nxt.status = owrs_pkg::ST_CRCERR;
          end else begin
            count_nxt   = count_inc;
            last_br_nxt = new_br_upd;
            new_br_nxt  = '0;
            out_data_nxt.rom_code     = path_upd;
            out_data_nxt.device_count = count_inc;
            if ((new_br_upd == '0) || (count_inc >= max_dev_r)) begin
              active_nxt = 1'b0;
              out_data_nxt.status = owrs_pkg::ST_DONE;
            end else begin
              out_data_nxt.status = owrs_pkg::ST_MORE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dev_r   <= owrs_pkg::MAX_DEVICES_RST;
      path_r      <= '0;
      last_br_r   <= '0;
      new_br_r    <= '0;
      bit_pos_r   <= owrs_pkg::POS_W'(1);
      count_r     <= '0;
      active_r    <= 1'b0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        max_dev_r <= cfg_pwdata[owrs_pkg::CNT_W-1:0];
      end
      path_r      <= path_nxt;
      last_br_r   <= last_br_nxt;
      new_br_r    <= new_br_nxt;
      bit_pos_r   <= bit_pos_nxt;
      count_r     <= count_nxt;
      active_r    <= active_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `ASSERT_IMPL(a_pos_range, clk, rst_n, 1'b1,
    (bit_pos_r != '0) && (bit_pos_r <= owrs_pkg::POS_W'(owrs_pkg::CODE_BITS)))
  `ASSERT_NEXT(a_begin_idle, clk, rst_n, in_fire && (in_data.op == owrs_pkg::OP_BEGIN),
    out_valid_r && (out_data_r.status == owrs_pkg::ST_IDLE) && (out_data_r.device_count == '0))
  `ASSERT_IMPL(a_stop_on_req, clk, rst_n, $fell(active_r), $past(in_fire))
  `ASSERT_NEXT(a_req_result, clk, rst_n, in_fire, out_valid_r)

endmodule

// ===== bench/owrs_checker.sv =====
`timescale 1ns / 1ps

module owrs_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  owrs_pkg::in_req_t                   in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  owrs_pkg::out_rsp_t                  out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [owrs_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [owrs_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  input  logic [owrs_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  input  logic                                cfg_pready,
  output int                                  fail_count,
  output int                                  outstanding,
  output int                                  checked,
  output int                                  codes,
  output int                                  stops
);

  localparam logic [owrs_pkg::CFG_ADDR_W-1:0] MAX_DEV_ADDR = {owrs_pkg::REG_MAX_DEVICES, 2'b00};

  logic [owrs_pkg::CNT_W-1:0]     max_dev;
  logic [owrs_pkg::CODE_BITS-1:0] path;
  logic [owrs_pkg::POS_W-1:0]     last_br;
  logic [owrs_pkg::POS_W-1:0]     new_br;
  logic [owrs_pkg::POS_W-1:0]     bit_pos;
  logic [owrs_pkg::CNT_W-1:0]     found;
  logic [owrs_pkg::CRC_W-1:0]     crc;
  logic                           active;
  owrs_pkg::out_rsp_t             expected_rsp_q[$];
  owrs_pkg::out_rsp_t             exp_rsp;

  task automatic report(input string msg);
    $display("MISMATCH %s", msg);
    fail_count++;
  endtask

  function automatic owrs_pkg::out_rsp_t search_step(input owrs_pkg::in_req_t req);
    owrs_pkg::out_rsp_t rsp;
    int                 pos;
    logic               chosen;
    logic               mix;
    rsp = '0;
    rsp.status = owrs_pkg::ST_IDLE;
    if (req.op == owrs_pkg::OP_BEGIN) begin
      path = '0;
      last_br = '0;
      new_br = '0;
      bit_pos = owrs_pkg::POS_W'(1);
      found = '0;
      crc = '0;
      active = (max_dev != 0);
    end else if (!active) begin
      rsp.status = owrs_pkg::ST_IDLE;
    end else if (req.bus_bit && req.bus_bit_complement) begin
      active = 1'b0;
      rsp.status = owrs_pkg::ST_NODEV;
    end else begin
      pos = (bit_pos < 1 || bit_pos > owrs_pkg::CODE_BITS) ? 1 : int'(bit_pos);
      if (req.bus_bit != req.bus_bit_complement) begin
        chosen = req.bus_bit;
      end else begin
        if (pos < last_br) chosen = path[pos-1];
        else chosen = (pos == last_br);
        if (!chosen) new_br = owrs_pkg::POS_W'(pos);
      end
      path[pos-1] = chosen;
      if (pos <= owrs_pkg::CRC_LAST_POS) begin
        mix = crc[0] ^ chosen;
        crc = crc >> 1;
        if (mix) crc = crc ^ owrs_pkg::CRC_POLY;
      end
      rsp.write_bit = chosen;
      rsp.status = owrs_pkg::ST_BIT;
      if (pos < owrs_pkg::CODE_BITS) begin
        bit_pos = owrs_pkg::POS_W'(pos + 1);
      end else begin
        bit_pos = owrs_pkg::POS_W'(1);
        if (crc != path[owrs_pkg::CODE_BITS-1:owrs_pkg::CRC_LAST_POS]) begin
          active = 1'b0;
          crc = '0;
          rsp.status = owrs_pkg::ST_CRCERR;
        end else begin
          crc = '0;
          if (found != '1) found = found + 1'b1;
          last_br = new_br;
          new_br = '0;
          rsp.rom_code = path;
          if (last_br == 0 || found >= max_dev) begin
            active = 1'b0;
            rsp.status = owrs_pkg::ST_DONE;
          end else begin
            rsp.status = owrs_pkg::ST_MORE;
          end
        end
      end
    end
    rsp.device_count = found;
    return rsp;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      max_dev = owrs_pkg::MAX_DEVICES_RST;
      path = '0;
      last_br = '0;
      new_br = '0;
      bit_pos = owrs_pkg::POS_W'(1);
      found = '0;
      crc = '0;
      active = 1'b0;
      expected_rsp_q.delete();
      fail_count = 0;
      checked = 0;
      codes = 0;
      stops = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == MAX_DEV_ADDR) begin
        if (cfg_pwrite) begin
          max_dev = cfg_pwdata[owrs_pkg::CNT_W-1:0];
        end else if (cfg_prdata !== owrs_pkg::CFG_DATA_W'(max_dev)) begin
          report($sformatf("max_devices readback: got %0h, expected %0h", cfg_prdata, max_dev));
        end
      end
      if (out_valid && out_ready) begin
        if (expected_rsp_q.size() == 0) begin
          report($sformatf("result with no request pending, status %0d", out_data.status));
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          checked++;
          if (exp_rsp.status == owrs_pkg::ST_MORE || exp_rsp.status == owrs_pkg::ST_DONE)
            codes++;
          if (exp_rsp.status == owrs_pkg::ST_NODEV || exp_rsp.status == owrs_pkg::ST_CRCERR)
            stops++;
          if (out_data.write_bit !== exp_rsp.write_bit)
            report($sformatf("result %0d write_bit: got %0b, expected %0b",
                             checked, out_data.write_bit, exp_rsp.write_bit));
          if (out_data.status !== exp_rsp.status)
            report($sformatf("result %0d status: got %0d, expected %0d",
                             checked, out_data.status, exp_rsp.status));
          if (out_data.rom_code !== exp_rsp.rom_code)
            report($sformatf("result %0d rom_code: got %016h, expected %016h",
                             checked, out_data.rom_code, exp_rsp.rom_code));
          if (out_data.device_count !== exp_rsp.device_count)
            report($sformatf("result %0d device_count: got %0d, expected %0d",
                             checked, out_data.device_count, exp_rsp.device_count));
        end
      end
      if (in_valid && in_ready) expected_rsp_q.push_back(search_step(in_data));
    end
    outstanding <= expected_rsp_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam logic [owrs_pkg::CFG_ADDR_W-1:0] MAX_DEV_ADDR = {owrs_pkg::REG_MAX_DEVICES, 2'b00};

  typedef enum logic [1:0] {
    SEARCH_CLEAN,
    SEARCH_ABORT,
    SEARCH_RESTART,
    SEARCH_NOISE
  } search_mode_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  owrs_pkg::in_req_t               in_data;
  logic                            out_valid;
  logic                            out_ready;
  owrs_pkg::out_rsp_t              out_data;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [owrs_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [owrs_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [owrs_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  int fail_count;
  int outstanding;
  int checked;
  int codes;
  int stops;

  int sent;
  int devices_driven;
  int cur_max;
  int in_calm;
  int out_calm;
  int out_hold;
  int out_roll;

  onewire_rom_search i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  owrs_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked),
    .codes       (codes),
    .stops       (stops)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_ready <= 1'b0;
    end else if (out_calm > 0) begin
      out_calm--;
      out_ready <= 1'b1;
    end else begin
      out_roll = $urandom_range(0, 99);
      if (out_roll < 2) begin
        out_calm = $urandom_range(40, 200);
        out_ready <= 1'b1;
      end else if (out_roll < 70) begin
        out_ready <= 1'b1;
      end else if (out_roll < 96) begin
        out_hold = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_hold = $urandom_range(9, 39);
        out_ready <= 1'b0;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (in_calm > 0) begin
      in_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) in_calm = $urandom_range(30, 150);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] code_crc(input logic [55:0] data);
    logic [7:0] c;
    c = '0;
    for (int i = 0; i < 56; i++)
      c = (c >> 1) ^ ((c[0] ^ data[i]) ? owrs_pkg::CRC_POLY : 8'h00);
    return c;
  endfunction

  // call at a falling edge; returns at a falling edge
  task automatic send_req(input logic op, input logic b, input logic bc);
    int gap;
    in_valid <= 1'b1;
    in_data <= '{op: op, bus_bit: b, bus_bit_complement: bc};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic apb_access(input logic wr, input logic [owrs_pkg::CNT_W-1:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= MAX_DEV_ADDR;
    cfg_pwdata <= owrs_pkg::CFG_DATA_W'(val);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_max_devices(input logic [owrs_pkg::CNT_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(negedge clk);
    apb_access(1'b1, val);
    apb_access(1'b0, '0);
    cur_max = int'(val);
  endtask

  // devices are held bit-reversed so that sorting gives the enumeration order
  task automatic run_search();
    logic [63:0]  devs[$];
    logic [63:0]  code;
    logic [63:0]  rev;
    logic         b;
    logic         bc;
    logic         dup;
    search_mode_t mode;
    int           n;
    int           lim;
    int           r;
    int           flip;
    int           cut_dev;
    int           cut_pos;
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 6);
    for (int i = 0; i < n; i++) begin
      if (devs.size() > 0 && $urandom_range(0, 1) == 1) begin
        code = {<<{devs[$urandom_range(0, devs.size() - 1)]}};
        flip = $urandom_range(0, 55);
        code[flip] = ~code[flip];
      end else begin
        code = {$urandom, $urandom};
      end
      code[63:56] = code_crc(code[55:0]);
      if ($urandom_range(0, 11) == 0) begin
        flip = $urandom_range(56, 63);
        code[flip] = ~code[flip];
      end
      rev = {<<{code}};
      dup = 1'b0;
      foreach (devs[d]) if (devs[d] == rev) dup = 1'b1;
      if (!dup) devs.push_back(rev);
    end
    devs.sort();
    r = $urandom_range(0, 99);
    mode = (r < 70) ? SEARCH_CLEAN : (r < 80) ? SEARCH_ABORT :
           (r < 90) ? SEARCH_RESTART : SEARCH_NOISE;
    lim = (cur_max < devs.size()) ? cur_max : devs.size();
    cut_dev = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
    cut_pos = $urandom_range(1, 64);
    send_req(owrs_pkg::OP_BEGIN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if (lim == 0) begin
      repeat (8)
        send_req(owrs_pkg::OP_BITS, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      return;
    end
    for (int k = 0; k < lim; k++) begin
      for (int p = 1; p <= 64; p++) begin
        if (k == cut_dev && p == cut_pos && mode == SEARCH_ABORT) begin
          send_req(owrs_pkg::OP_BITS, 1'b1, 1'b1);
          return;
        end
        if (k == cut_dev && p == cut_pos && mode == SEARCH_RESTART) begin
          send_req(owrs_pkg::OP_BEGIN, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          return;
        end
        b = 1'b1;
        bc = 1'b1;
        foreach (devs[d]) begin
          if ((devs[d] >> (65 - p)) == (devs[k] >> (65 - p))) begin
            b = b & devs[d][64-p];
            bc = bc & ~devs[d][64-p];
          end
        end
        if (mode == SEARCH_NOISE && $urandom_range(0, 15) == 0) begin
          b = 1'($urandom_range(0, 1));
          bc = 1'($urandom_range(0, 1));
        end
        send_req(owrs_pkg::OP_BITS, b, bc);
      end
      devices_driven++;
      code = {<<{devs[k]}};
      if (code[63:56] != code_crc(code[55:0])) return;
    end
  endtask

  initial begin
    int ph;
    int start;
    logic [owrs_pkg::CNT_W-1:0] mx;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cur_max = int'(owrs_pkg::MAX_DEVICES_RST);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_req(owrs_pkg::OP_BITS, 1'b0, 1'b0);
    send_req(owrs_pkg::OP_BITS, 1'b1, 1'b1);
    send_req(owrs_pkg::OP_BEGIN, 1'b1, 1'b1);
    send_req(owrs_pkg::OP_BITS, 1'b0, 1'b1);
    send_req(owrs_pkg::OP_BITS, 1'b1, 1'b0);
    send_req(owrs_pkg::OP_BITS, 1'b0, 1'b0);
    send_req(owrs_pkg::OP_BITS, 1'b1, 1'b1);
    send_req(owrs_pkg::OP_BITS, 1'b1, 1'b0);
    send_req(owrs_pkg::OP_BEGIN, 1'b0, 1'b0);
    send_req(owrs_pkg::OP_BITS, 1'b0, 1'b0);
    send_req(owrs_pkg::OP_BITS, 1'b0, 1'b1);
    send_req(owrs_pkg::OP_BEGIN, 1'b0, 1'b1);
    send_req(owrs_pkg::OP_BITS, 1'b1, 1'b0);
    send_req(owrs_pkg::OP_BEGIN, 1'b1, 1'b0);

    for (ph = 0; ph < 16; ph++) begin
      if (ph > 0) begin
        case (ph)
          1:       mx = 8'd1;
          2:       mx = 8'd0;
          3:       mx = 8'd255;
          4:       mx = 8'd2;
          default: mx = ($urandom_range(0, 4) == 0) ? 8'd255 :
                        owrs_pkg::CNT_W'($urandom_range(1, 8));
        endcase
        set_max_devices(mx);
      end
      start = sent;
      while (sent - start < 60) run_search();
      if (ph >= 4 && sent >= 560) break;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Ran %0d requests, %0d results checked, %0d device codes reported",
             sent, checked, codes);
    $display("  %0d device walks, %0d searches stopped on no-device or CRC error",
             devices_driven, stops);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
